// ===== rtl/tli_pkg.sv =====
// Shared types and constants for the table linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

  // Field widths of the item formats.
  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 10;
  localparam int COUNT_BITS = 11;

  // Long division retires two quotient bits per cycle over a double-width dividend.
  localparam int DIV_CYCLES = VALUE_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Item kinds.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Table read address selection.
  localparam logic [2:0] ADDR_FIRST = 3'd0;
  localparam logic [2:0] ADDR_LAST  = 3'd1;
  localparam logic [2:0] ADDR_MID   = 3'd2;
  localparam logic [2:0] ADDR_LO    = 3'd3;
  localparam logic [2:0] ADDR_NEXT  = 3'd4;

  // Result selection.
  localparam logic [1:0] RES_OOR    = 2'd0;
  localparam logic [1:0] RES_Y0     = 2'd1;
  localparam logic [1:0] RES_INTERP = 2'd2;

  typedef struct packed {
    logic                         action;
    logic [INDEX_BITS-1:0]        point_index;
    logic signed [VALUE_BITS-1:0] point_x;
    logic signed [VALUE_BITS-1:0] point_y;
    logic signed [VALUE_BITS-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] interp_y;
    logic                         out_of_range;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_point;
    logic       capture_query;
    logic [2:0] addr_sel;
    logic       note_below;
    logic       init_search;
    logic       step_search;
    logic       take_lower;
    logic       take_diffs;
    logic       start_div;
    logic       div_step;
    logic       res_load;
    logic [1:0] res_sel;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_of_range;
    logic lo_lt_hi;
    logic direct;
    logic div_last;
  } status_t;

endpackage

// ===== rtl/tli_datapath.sv =====
// Datapath: breakpoint memories, search registers, multiplier, divider and result registers.
`timescale 1ns / 1ps

module tli_datapath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tli_pkg::COUNT_BITS-1:0]      cfg_wr_data,
  input  tli_pkg::in_item_t                   in_data,
  input  tli_pkg::cmd_t                       cmd,
  output tli_pkg::status_t                    status,
  output tli_pkg::out_item_t                  out_data
);

  localparam int          VB     = tli_pkg::VALUE_BITS;
  localparam int          AddrW  = $clog2(MAX_POINTS);
  localparam logic [31:0] MaxPts = 32'(MAX_POINTS);

  // Breakpoint memories.
  logic signed [VB-1:0] mem_x [MAX_POINTS];
  logic signed [VB-1:0] mem_y [MAX_POINTS];

  logic [tli_pkg::COUNT_BITS-1:0] pts_r;
  logic signed [VB-1:0]           q_r;
  logic [AddrW-1:0]               last_r;
  logic signed [VB-1:0]           rd_x_r, rd_y_r;
  logic                           below_r;
  logic [AddrW-1:0]               lo_r, hi_r;
  logic signed [VB-1:0]           x0_r, y0_r;
  logic [VB-1:0]                  mag_dx_r, mag_dy_r, mag_dq_r;
  logic                           neg_r;
  logic [2*VB-1:0]                dvd_r;
  logic [VB-1:0]                  rem_r;
  logic [tli_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic signed [VB-1:0]           res_r;
  logic                           res_oor_r;
  tli_pkg::out_item_t             out_data_r;

  logic [31:0]      n_ext, n_eff, idx_ext;
  logic [AddrW-1:0] last_nxt, wr_addr, rd_addr, mid;
  logic [AddrW:0]   mid_sum;
  logic             wr_ok;

  // Number of points in use, clamped to the table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= tli_pkg::COUNT_BITS'(1);
    end else if (cfg_wr_en) begin
      pts_r <= cfg_wr_data;
    end
  end

  always_comb begin
    n_ext = 32'(pts_r);
    if (n_ext == 32'd0) begin
      n_eff = 32'd1;
    end else if (n_ext > MaxPts) begin
      n_eff = MaxPts;
    end else begin
      n_eff = n_ext;
    end
    last_nxt = AddrW'(n_eff - 32'd1);
    idx_ext  = 32'(in_data.point_index);
    wr_ok    = idx_ext < MaxPts;
    wr_addr  = AddrW'(idx_ext);
    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + (AddrW + 1)'(1);
    mid      = mid_sum[AddrW:1];
  end

  // Read address selection.
  always_comb begin
    case (cmd.addr_sel)
      tli_pkg::ADDR_FIRST: rd_addr = '0;
      tli_pkg::ADDR_LAST:  rd_addr = last_r;
      tli_pkg::ADDR_MID:   rd_addr = mid;
      tli_pkg::ADDR_LO:    rd_addr = lo_r;
      tli_pkg::ADDR_NEXT:  rd_addr = lo_r + AddrW'(1);
      default:             rd_addr = '0;
    endcase
  end

  // One write port and one registered read port per memory.
  always_ff @(posedge clk) begin
    if (cmd.write_point && wr_ok) begin
      mem_x[wr_addr] <= in_data.point_x;
      mem_y[wr_addr] <= in_data.point_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // Interval differences and their magnitudes.
  logic signed [VB:0] dx_w, dy_w, dq_w;
  logic [VB:0]        dx_abs, dy_abs, dq_abs;

  always_comb begin
    dx_w   = {rd_x_r[VB-1], rd_x_r} - {x0_r[VB-1], x0_r};
    dy_w   = {rd_y_r[VB-1], rd_y_r} - {y0_r[VB-1], y0_r};
    dq_w   = {q_r[VB-1], q_r} - {x0_r[VB-1], x0_r};
    dx_abs = dx_w[VB] ? (~dx_w + (VB + 1)'(1)) : dx_w;
    dy_abs = dy_w[VB] ? (~dy_w + (VB + 1)'(1)) : dy_w;
    dq_abs = dq_w[VB] ? (~dq_w + (VB + 1)'(1)) : dq_w;
  end

  // Two restoring division steps per cycle.
  logic [VB:0]     rem_a, rem_b, sub_a, sub_b;
  logic            ge_a, ge_b;
  logic [VB-1:0]   rem_mid, rem_nxt;
  logic [2*VB-1:0] dvd_mid, dvd_nxt;

  always_comb begin
    rem_a   = {rem_r, dvd_r[2*VB-1]};
    ge_a    = rem_a >= {1'b0, mag_dx_r};
    sub_a   = rem_a - {1'b0, mag_dx_r};
    rem_mid = ge_a ? sub_a[VB-1:0] : rem_a[VB-1:0];
    dvd_mid = {dvd_r[2*VB-2:0], ge_a};
    rem_b   = {rem_mid, dvd_mid[2*VB-1]};
    ge_b    = rem_b >= {1'b0, mag_dx_r};
    sub_b   = rem_b - {1'b0, mag_dx_r};
    rem_nxt = ge_b ? sub_b[VB-1:0] : rem_b[VB-1:0];
    dvd_nxt = {dvd_mid[2*VB-2:0], ge_b};
  end

  // Apply the quotient to the lower ordinate and saturate.
  logic               q_big;
  logic [VB+1:0]      q_sat;
  logic signed [VB+3:0] sum_w;
  logic signed [VB-1:0] interp_w;

  always_comb begin
    q_big = |dvd_r[2*VB-1:VB+1];
    q_sat = q_big ? {1'b1, (VB + 1)'(0)} : {1'b0, dvd_r[VB:0]};
    if (neg_r) begin
      sum_w = {{4{y0_r[VB-1]}}, y0_r} - {2'b00, q_sat};
    end else begin
      sum_w = {{4{y0_r[VB-1]}}, y0_r} + {2'b00, q_sat};
    end
    if ((&sum_w[VB+3:VB-1]) || !(|sum_w[VB+3:VB-1])) begin
      interp_w = sum_w[VB-1:0];
    end else if (sum_w[VB+3]) begin
      interp_w = {1'b1, (VB - 1)'(0)};
    end else begin
      interp_w = {1'b0, {(VB - 1){1'b1}}};
    end
  end

  // Search, operand and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.capture_query) begin
      q_r    <= in_data.query_x;
      last_r <= last_nxt;
    end
    if (cmd.note_below) begin
      below_r <= q_r < rd_x_r;
    end
    if (cmd.init_search) begin
      lo_r <= '0;
      hi_r <= last_r;
    end else if (cmd.step_search) begin
      if (rd_x_r <= q_r) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid - AddrW'(1);
      end
    end
    if (cmd.take_lower) begin
      x0_r <= rd_x_r;
      y0_r <= rd_y_r;
    end
    if (cmd.take_diffs) begin
      mag_dx_r <= dx_abs[VB-1:0];
      mag_dy_r <= dy_abs[VB-1:0];
      mag_dq_r <= dq_abs[VB-1:0];
      neg_r    <= dy_w[VB] ^ dx_w[VB] ^ dq_w[VB];
    end
    if (cmd.start_div) begin
      dvd_r <= mag_dy_r * mag_dq_r;
      rem_r <= '0;
      cnt_r <= tli_pkg::DIV_CNT_W'(tli_pkg::DIV_CYCLES - 1);
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - tli_pkg::DIV_CNT_W'(1);
    end
  end

  // Result register and output register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        tli_pkg::RES_OOR: begin
          res_r     <= '0;
          res_oor_r <= 1'b1;
        end
        tli_pkg::RES_Y0: begin
          res_r     <= y0_r;
          res_oor_r <= 1'b0;
        end
        tli_pkg::RES_INTERP: begin
          res_r     <= interp_w;
          res_oor_r <= 1'b0;
        end
        default: begin
          res_r     <= res_r;
          res_oor_r <= res_oor_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_data_r.interp_y     <= res_r;
      out_data_r.out_of_range <= res_oor_r;
    end
  end

  // Status to the controller.
  always_comb begin
    status.out_of_range = below_r || (q_r > rd_x_r);
    status.lo_lt_hi     = lo_r < hi_r;
    status.direct       = (lo_r == last_r) || (dx_w == '0);
    status.div_last     = cnt_r == '0;
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/tli_ctrl.sv =====
// Controller: sequences range check, binary search, interpolation and result hand-off.
`timescale 1ns / 1ps

module tli_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  output logic             out_valid,
  input  logic             out_ready,
  input  tli_pkg::status_t status,
  output tli_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_FIRST = 4'd1;
  localparam logic [3:0] S_RD_LAST  = 4'd2;
  localparam logic [3:0] S_CHK      = 4'd3;
  localparam logic [3:0] S_SEARCH   = 4'd4;
  localparam logic [3:0] S_CMP      = 4'd5;
  localparam logic [3:0] S_RD_LO    = 4'd6;
  localparam logic [3:0] S_RD_NEXT  = 4'd7;
  localparam logic [3:0] S_DIFF     = 4'd8;
  localparam logic [3:0] S_MUL      = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.addr_sel = tli_pkg::ADDR_FIRST;
    cmd.res_sel  = tli_pkg::RES_OOR;
    case (state_r)
      S_IDLE: begin
        cmd.write_point   = accept && (in_action == tli_pkg::ACT_LOAD);
        cmd.capture_query = accept && (in_action == tli_pkg::ACT_QUERY);
        if (cmd.capture_query) begin
          state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.addr_sel = tli_pkg::ADDR_FIRST;
        state_nxt    = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.addr_sel   = tli_pkg::ADDR_LAST;
        cmd.note_below = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CHK: begin
        if (status.out_of_range) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tli_pkg::RES_OOR;
          state_nxt    = S_DONE;
        end else begin
          cmd.init_search = 1'b1;
          state_nxt       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.addr_sel = tli_pkg::ADDR_MID;
        state_nxt    = status.lo_lt_hi ? S_CMP : S_RD_LO;
      end
      S_CMP: begin
        cmd.step_search = 1'b1;
        state_nxt       = S_SEARCH;
      end
      S_RD_LO: begin
        cmd.addr_sel = tli_pkg::ADDR_LO;
        state_nxt    = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        cmd.addr_sel   = tli_pkg::ADDR_NEXT;
        cmd.take_lower = 1'b1;
        state_nxt      = S_DIFF;
      end
      S_DIFF: begin
        if (status.direct) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tli_pkg::RES_Y0;
          state_nxt    = S_DONE;
        end else begin
          cmd.take_diffs = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.start_div = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = tli_pkg::RES_INTERP;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register is free once its item has been taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/table_linear_interpolator_core.sv =====
// Piecewise linear interpolator over a loadable breakpoint table: top level.
//
// Input channel (in_valid/in_ready/in_data): an item with action load writes one
// breakpoint (x, y) into slot point_index; an item with action query asks for the
// interpolated y at query_x. Values are signed Q16.16, x ascending in the table.
// Result channel (out_valid/out_ready/out_data): one item per query, none per load.
// cfg_wr_en/cfg_wr_data set points_in_use; the user must write it only while the
// block is idle, which the block itself does not enforce. Loads are taken one per
// cycle while no query is in progress. A query holds the input channel until its
// result has been placed in the output register. The first and last points are
// read for the range check; a query outside the table gets the out-of-range result
// directly. Otherwise a binary search of at most log2(MAX_POINTS) probes, each a read
// of the single table port, finds the interval; on the last point or a zero-width
// interval y0 is taken, else the multiplier and two-bit-per-cycle divider work it out.
// The output register decouples the sides: if the receiver stalls, the next item
// is still accepted and worked on, and only its hand-off waits for the register.
// Synchronous reset empties the output register, returns the controller to idle
// and sets points_in_use to 1; table contents are undefined until loaded.
`timescale 1ns / 1ps

module table_linear_interpolator_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tli_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tli_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [tli_pkg::COUNT_BITS-1:0] cfg_wr_data
);

  tli_pkg::cmd_t    cmd;
  tli_pkg::status_t status;

  // Sequencer.
  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, arithmetic and result registers.
  tli_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/tli_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
`timescale 1ns / 1ps

module tli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input tli_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input tli_pkg::out_item_t out_data
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A query occupies the block, so input is refused in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == tli_pkg::ACT_QUERY) |=> !in_ready)
    else $error("input accepted directly after a query");

  // A load leaves the input ready again in the next cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == tli_pkg::ACT_LOAD) |=> in_ready)
    else $error("load item stalled the input");

  // An out-of-range result carries a zero ordinate.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.interp_y == '0)
    else $error("out-of-range result with non-zero ordinate");

endmodule

bind table_linear_interpolator_core tli_checker u_tli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/table_linear_interpolator_core_test.sv =====
// Self-checking testbench for the table linear interpolator core.
`timescale 1ns / 1ps

module table_linear_interpolator_core_test;

  localparam int     DEPTH         = 1024;
  localparam int     SETTLE_CYCLES = 80;
  localparam int     STALL_LIMIT   = 2000;
  localparam int     PHASE_QUERIES = 32;
  localparam longint VAL_MAX       = 64'sd2147483647;
  localparam longint VAL_MIN       = -64'sd2147483648;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  tli_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  tli_pkg::out_item_t             out_data;
  logic                           cfg_wr_en;
  logic [tli_pkg::COUNT_BITS-1:0] cfg_wr_data;

  // Shadow of the breakpoint table and of the point count.
  logic signed [tli_pkg::VALUE_BITS-1:0] knot_x [DEPTH];
  logic signed [tli_pkg::VALUE_BITS-1:0] knot_y [DEPTH];
  logic [tli_pkg::COUNT_BITS-1:0]        points_setting;

  // Interpolated answers still owed by the block, oldest first.
  tli_pkg::out_item_t answers_due [$];

  int error_count = 0;
  int idle_stretch = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  table_linear_interpolator_core #(
    .MAX_POINTS(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A point count of zero searches one point; counts above the depth search all of it.
  function automatic int effective_points();
    if (points_setting < 1) return 1;
    if (points_setting > DEPTH) return DEPTH;
    return int'(points_setting);
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Binary search for the bracketing interval, then y0 + dy * dq / dx with the
  // quotient truncated towards zero and the sum saturated to the value width.
  function automatic tli_pkg::out_item_t interpolated_answer(
      logic signed [tli_pkg::VALUE_BITS-1:0] q);
    int                 n, lo, hi, mid;
    longint             y0, dx, dy, dq, res;
    logic [127:0]       quot;
    bit                 neg;
    tli_pkg::out_item_t ans;
    n = effective_points();
    ans.interp_y = '0;
    ans.out_of_range = 1'b1;
    if (q < knot_x[0] || q > knot_x[n-1]) return ans;
    ans.out_of_range = 1'b0;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (knot_x[mid] <= q) lo = mid;
      else hi = mid - 1;
    end
    y0 = knot_y[lo];
    res = y0;
    if (lo < n - 1) begin
      dx = longint'(knot_x[lo+1]) - longint'(knot_x[lo]);
      if (dx != 0) begin
        dy = longint'(knot_y[lo+1]) - y0;
        dq = longint'(q) - longint'(knot_x[lo]);
        neg = ((dy < 0) != (dx < 0)) != (dq < 0);
        quot = (128'(magnitude(dy)) * 128'(magnitude(dq))) / 128'(magnitude(dx));
        if (quot > (128'd1 << 62)) quot = 128'd1 << 62;
        res = neg ? y0 - longint'(quot[63:0]) : y0 + longint'(quot[63:0]);
      end
    end
    if (res > VAL_MAX) res = VAL_MAX;
    if (res < VAL_MIN) res = VAL_MIN;
    ans.interp_y = res[tli_pkg::VALUE_BITS-1:0];
    return ans;
  endfunction

  // Random value with a bias towards the extremes of the signed range.
  function automatic logic signed [tli_pkg::VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tli_pkg::in_item_t load_item(int idx,
                                                  logic signed [tli_pkg::VALUE_BITS-1:0] x,
                                                  logic signed [tli_pkg::VALUE_BITS-1:0] y);
    tli_pkg::in_item_t item;
    item.action      = tli_pkg::ACT_LOAD;
    item.point_index = tli_pkg::INDEX_BITS'(idx);
    item.point_x     = x;
    item.point_y     = y;
    item.query_x     = $urandom;
    return item;
  endfunction

  function automatic tli_pkg::in_item_t query_item(logic signed [tli_pkg::VALUE_BITS-1:0] q);
    tli_pkg::in_item_t item;
    item.action      = tli_pkg::ACT_QUERY;
    item.point_index = tli_pkg::INDEX_BITS'($urandom);
    item.point_x     = $urandom;
    item.point_y     = $urandom;
    item.query_x     = q;
    return item;
  endfunction

  // Mostly inside the table, some on a breakpoint, some just outside it.
  function automatic logic signed [tli_pkg::VALUE_BITS-1:0] pick_query(int n);
    longint      first, last, v;
    logic [63:0] span;
    int          sel;
    first = knot_x[0];
    last  = knot_x[n-1];
    sel   = $urandom_range(0, 19);
    if (sel < 11 && first <= last) begin
      span = last - first + 1;
      v = first + longint'({$urandom, $urandom} % span);
    end else if (sel < 14) begin
      v = knot_x[$urandom_range(0, n - 1)];
    end else if (sel < 16 && first > VAL_MIN) begin
      v = first - 1 - longint'($urandom_range(0, 255));
      if (v < VAL_MIN) v = VAL_MIN;
    end else if (sel < 18 && last < VAL_MAX) begin
      v = last + 1 + longint'($urandom_range(0, 255));
      if (v > VAL_MAX) v = VAL_MAX;
    end else begin
      v = rand_value();
    end
    return v[tli_pkg::VALUE_BITS-1:0];
  endfunction

  // Offer one item, with random idle cycles in front, and update the shadow
  // state at the edge where it is taken.
  task automatic send_item(input tli_pkg::in_item_t item);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.action == tli_pkg::ACT_LOAD) begin
      knot_x[item.point_index] = item.point_x;
      knot_y[item.point_index] = item.point_y;
    end else begin
      answers_due.push_back(interpolated_answer(item.query_x));
    end
  endtask

  // Stop offering items, collect every answer owed and let a trailing load settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_points(input logic [tli_pkg::COUNT_BITS-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    points_setting = value;
  endtask

  // Fill slots 0 to n-1, either with ascending x (some repeated) or at random.
  task automatic load_table(input int n, input bit ascending);
    longint step_max, x;
    step_max = (64'sd4294967295 / n) >> $urandom_range(0, 20);
    x = VAL_MIN + longint'($urandom_range(0, 32'(step_max)));
    for (int i = 0; i < n; i++) begin
      if (ascending && i > 0 && $urandom_range(0, 7) != 0)
        x = x + longint'($urandom_range(0, 32'(step_max)));
      send_item(load_item(i, ascending ? x[tli_pkg::VALUE_BITS-1:0] : rand_value(),
                          rand_value()));
    end
  endtask

  task automatic send_random_queries(input int count);
    for (int i = 0; i < count; i++) send_item(query_item(pick_query(effective_points())));
  endtask

  // A single point after reset, then a point count of zero, which searches one point.
  task automatic test_reset_single_point();
    send_item(load_item(0, 32'sh0001_0000, 32'sh0003_0000));
    send_item(query_item(32'sh0001_0000));
    send_item(query_item(32'sh0000_FFFF));
    send_item(query_item(32'sh0001_0001));
    drain_results();
    set_points('0);
    send_item(query_item(32'sh0001_0000));
    send_item(query_item(32'sh8000_0000));
    drain_results();
    set_points(11'd1);
    send_item(query_item(32'sh7FFF_FFFF));
  endtask

  // Breakpoints spanning the full value range, with a repeated x and the widest steps in y.
  task automatic test_extremes();
    drain_results();
    set_points(11'd5);
    send_item(load_item(0, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(load_item(1, -32'sh0001_0000, 32'sh8000_0000));
    send_item(load_item(2, -32'sh0001_0000, 32'sh0001_0000));
    send_item(load_item(3, 32'sh0001_8000, -32'sh1));
    send_item(load_item(4, 32'sh7FFF_FFFF, 32'sh0000_3039));
    send_item(query_item(32'sh8000_0000));
    send_item(query_item(32'sh8000_0001));
    send_item(query_item(-32'sh0001_0001));
    send_item(query_item(-32'sh0001_0000));
    send_item(query_item(32'sh0001_7FFF));
    send_item(query_item(32'sh0001_8000));
    send_item(query_item(32'sh7FFF_FFFE));
    send_item(query_item(32'sh7FFF_FFFF));
  endtask

  // Queries below the first and above the last point, and on both ends.
  task automatic test_out_of_range();
    drain_results();
    set_points(11'd2);
    send_item(load_item(0, -32'sd100, 32'sh0004_0000));
    send_item(load_item(1, 32'sd100, -32'sh0004_0000));
    send_item(query_item(32'sh8000_0000));
    send_item(query_item(-32'sd101));
    send_item(query_item(-32'sd100));
    send_item(query_item(32'sd100));
    send_item(query_item(32'sd101));
    send_item(query_item(32'sh7FFF_FFFF));
  endtask

  // Every slot loaded, searched with the full count and with counts beyond it.
  task automatic test_full_table();
    drain_results();
    set_points(tli_pkg::COUNT_BITS'(DEPTH));
    load_table(DEPTH, 1'b1);
    send_item(query_item(knot_x[0]));
    send_item(query_item(knot_x[DEPTH-1]));
    send_random_queries(10);
    drain_results();
    set_points(11'd2047);
    send_random_queries(6);
    drain_results();
    set_points(tli_pkg::COUNT_BITS'(DEPTH + 1));
    send_random_queries(6);
  endtask

  // Phases of a fresh table and random queries, cycling through the idling patterns.
  task automatic test_random_phases();
    int n;
    for (int phase = 0; phase < 12; phase++) begin
      drain_results();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
      case ($urandom_range(0, 7))
        0: n = 1;
        1: n = 2;
        default: n = $urandom_range(3, 24);
      endcase
      if ($urandom_range(0, 11) == 0) n = $urandom_range(100, 300);
      set_points((n == 1 && $urandom_range(0, 1) == 0) ? '0 : tli_pkg::COUNT_BITS'(n));
      load_table(n, $urandom_range(0, 7) != 0);
      for (int i = 0; i < PHASE_QUERIES; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(load_item($urandom_range(0, DEPTH - 1), rand_value(), rand_value()));
        else
          send_item(query_item(pick_query(effective_points())));
      end
    end
  endtask

  // Result checking and random back-pressure.
  always @(posedge clk) begin
    tli_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        error_count++;
        $error("result item with no query outstanding: interp_y %0d, out_of_range %0b",
               out_data.interp_y, out_data.out_of_range);
      end else begin
        want = answers_due.pop_front();
        if (out_data.interp_y !== want.interp_y) begin
          error_count++;
          $error("interp_y: expected %0d, actual %0d", want.interp_y, out_data.interp_y);
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          error_count++;
          $error("out_of_range: expected %0b, actual %0b", want.out_of_range,
                 out_data.out_of_range);
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_stretch <= 0;
    end else if (idle_stretch >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_stretch <= idle_stretch + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    points_setting = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_single_point();
    test_extremes();
    test_out_of_range();
    test_full_table();
    test_random_phases();

    drain_results();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
